// ===== hdl/ejh_pkg.sv =====
package ejh_pkg;

    // sizes
    localparam int HEAP_DEPTH = 64;
    localparam int ADDR_W     = $clog2(HEAP_DEPTH);
    localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
    localparam int KID_W      = ADDR_W + 2;
    localparam int TIME_W     = 32;
    localparam int TID_W      = 8;

    // command codes
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // policy codes
    localparam logic POL_EDF = 1'b0;
    localparam logic POL_RM  = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // one heap entry
    typedef struct packed {
        logic [TID_W-1:0]  tid;
        logic [TIME_W-1:0] dl;
        logic [TIME_W-1:0] ex;
        logic [TIME_W-1:0] per;
    } job_t;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_UP_RD,
        S_UP_CMP,
        S_POP_CAP,
        S_DN_RD,
        S_DN_CMP,
        S_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic    load_in;
        logic    res_set;
        status_t res_code;
        logic    push_begin;
        logic    rd_parent;
        logic    rd_root;
        logic    rd_kids;
        logic    cap_pop;
        logic    wr_move_up;
        logic    wr_move_down;
        logic    wr_final;
        logic    ld_out;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_pop;
        logic full;
        logic empty;
        logic idx_zero;
        logic has_child;
        logic parent_holds;
        logic child_holds;
        logic out_busy;
    } stat_t;

    // earliest deadline, then larger exec time, then lower task id
    function automatic logic edf_above(job_t a, job_t b);
        logic r;
        if (a.dl != b.dl)
            r = (a.dl < b.dl);
        else if (a.ex != b.ex)
            r = (a.ex > b.ex);
        else
            r = (a.tid < b.tid);
        return r;
    endfunction

    // upper entry stays above the moving one
    function automatic logic stays_above(logic pol, job_t upper, job_t mover);
        logic r;
        if (pol == POL_RM)
            r = (upper.per <= mover.per);
        else
            r = edf_above(upper, mover);
        return r;
    endfunction

    // right child chosen over left child
    function automatic logic right_wins(logic pol, job_t r_job, job_t l_job);
        logic r;
        if (pol == POL_RM)
            r = (r_job.per < l_job.per);
        else
            r = edf_above(r_job, l_job);
        return r;
    endfunction

endpackage

// ===== hdl/ejh_ctrl.sv =====
module ejh_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  ejh_pkg::stat_t st,
    output ejh_pkg::cmd_t  cmd
);

    ejh_pkg::state_t state_reg;
    ejh_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ejh_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        cmd          = '0;
        cmd.res_code = ejh_pkg::ST_OK;
        unique case (state_reg)
            ejh_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ejh_pkg::S_START;
                end
            end
            ejh_pkg::S_START:
            begin
                cmd.res_set = 1'b1;
                if (!st.is_pop)
                begin
                    if (st.full)
                    begin
                        cmd.res_code = ejh_pkg::ST_FULL;
                        state_next   = ejh_pkg::S_DONE;
                    end
                    else
                    begin
                        cmd.push_begin = 1'b1;
                        state_next     = ejh_pkg::S_UP_RD;
                    end
                end
                else
                begin
                    if (st.empty)
                    begin
                        cmd.res_code = ejh_pkg::ST_EMPTY;
                        state_next   = ejh_pkg::S_DONE;
                    end
                    else
                    begin
                        cmd.rd_root = 1'b1;
                        state_next  = ejh_pkg::S_POP_CAP;
                    end
                end
            end
            // sift up: read parent
            ejh_pkg::S_UP_RD:
            begin
                if (st.idx_zero)
                begin
                    cmd.wr_final = 1'b1;
                    state_next   = ejh_pkg::S_DONE;
                end
                else
                begin
                    cmd.rd_parent = 1'b1;
                    state_next    = ejh_pkg::S_UP_CMP;
                end
            end
            // sift up: compare and move
            ejh_pkg::S_UP_CMP:
            begin
                if (st.parent_holds)
                begin
                    cmd.wr_final = 1'b1;
                    state_next   = ejh_pkg::S_DONE;
                end
                else
                begin
                    cmd.wr_move_up = 1'b1;
                    state_next     = ejh_pkg::S_UP_RD;
                end
            end
            ejh_pkg::S_POP_CAP:
            begin
                cmd.cap_pop = 1'b1;
                state_next  = ejh_pkg::S_DN_RD;
            end
            // sift down: read both children
            ejh_pkg::S_DN_RD:
            begin
                if (!st.has_child)
                begin
                    cmd.wr_final = 1'b1;
                    state_next   = ejh_pkg::S_DONE;
                end
                else
                begin
                    cmd.rd_kids = 1'b1;
                    state_next  = ejh_pkg::S_DN_CMP;
                end
            end
            // sift down: pick child, compare and move
            ejh_pkg::S_DN_CMP:
            begin
                if (st.child_holds)
                begin
                    cmd.wr_final = 1'b1;
                    state_next   = ejh_pkg::S_DONE;
                end
                else
                begin
                    cmd.wr_move_down = 1'b1;
                    state_next       = ejh_pkg::S_DN_RD;
                end
            end
            ejh_pkg::S_DONE:
            begin
                if (!st.out_busy)
                begin
                    cmd.ld_out = 1'b1;
                    state_next = ejh_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ejh_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/ejh_dp.sv =====
module ejh_dp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic                       cfg_wr_data,
    input  logic                       command,
    input  logic [ejh_pkg::TID_W-1:0]  task_id,
    input  logic [ejh_pkg::TIME_W-1:0] abs_deadline,
    input  logic [ejh_pkg::TIME_W-1:0] last_exec_time,
    input  logic [ejh_pkg::TIME_W-1:0] period,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       job_valid,
    output logic [ejh_pkg::TID_W-1:0]  out_task_id,
    output logic [ejh_pkg::TIME_W-1:0] out_abs_deadline,
    output logic [ejh_pkg::TIME_W-1:0] out_last_exec_time,
    output logic [ejh_pkg::TIME_W-1:0] out_period,
    output logic [1:0]                 status,
    output logic                       is_empty,
    output logic [ejh_pkg::CNT_W-1:0]  job_count,
    input  ejh_pkg::cmd_t              cmd,
    output ejh_pkg::stat_t             st
);

    ejh_pkg::job_t heap_mem [ejh_pkg::HEAP_DEPTH];

    logic                         policy_reg;
    logic                         cmd_reg;
    ejh_pkg::job_t                job_reg;
    ejh_pkg::job_t                top_reg;
    logic [ejh_pkg::ADDR_W-1:0]   idx_reg;
    logic [ejh_pkg::CNT_W-1:0]    count_reg;
    ejh_pkg::status_t             res_reg;
    ejh_pkg::job_t                rd_a_reg;
    ejh_pkg::job_t                rd_b_reg;
    logic                         out_valid_reg;
    logic                         job_valid_reg;
    ejh_pkg::job_t                out_job_reg;
    ejh_pkg::status_t             out_status_reg;
    logic [ejh_pkg::CNT_W-1:0]    out_count_reg;

    logic [ejh_pkg::ADDR_W-1:0]   parent_idx;
    logic [ejh_pkg::KID_W-1:0]    kid_l;
    logic [ejh_pkg::KID_W-1:0]    kid_r;
    logic [ejh_pkg::KID_W-1:0]    count_ext;
    logic                         right_sel;
    ejh_pkg::job_t                child_job;
    logic [ejh_pkg::ADDR_W-1:0]   child_idx;
    logic                         rd_en;
    logic [ejh_pkg::ADDR_W-1:0]   raddr_a;
    logic [ejh_pkg::ADDR_W-1:0]   raddr_b;
    logic                         wr_en;
    ejh_pkg::job_t                wr_data;
    ejh_pkg::job_t                in_job;
    logic                         pop_ok;

    // index arithmetic
    assign parent_idx = (idx_reg - ejh_pkg::ADDR_W'(1)) >> 1;
    assign kid_l      = {1'b0, idx_reg, 1'b1};
    assign kid_r      = kid_l + ejh_pkg::KID_W'(1);
    assign count_ext  = ejh_pkg::KID_W'(count_reg);

    // child selection for sift down
    assign right_sel = (kid_r < count_ext) &&
                       ejh_pkg::right_wins(policy_reg, rd_b_reg, rd_a_reg);
    assign child_job = right_sel ? rd_b_reg : rd_a_reg;
    assign child_idx = right_sel ? kid_r[ejh_pkg::ADDR_W-1:0]
                                 : kid_l[ejh_pkg::ADDR_W-1:0];

    // status to controller
    assign st.is_pop       = (cmd_reg == ejh_pkg::CMD_POP);
    assign st.full         = (count_reg == ejh_pkg::CNT_W'(ejh_pkg::HEAP_DEPTH));
    assign st.empty        = (count_reg == '0);
    assign st.idx_zero     = (idx_reg == '0);
    assign st.has_child    = (kid_l < count_ext);
    assign st.parent_holds = ejh_pkg::stays_above(policy_reg, rd_a_reg, job_reg);
    assign st.child_holds  = ejh_pkg::stays_above(policy_reg, job_reg, child_job);
    assign st.out_busy     = out_valid_reg & ~out_ready;

    // read port addresses
    assign rd_en = cmd.rd_parent | cmd.rd_root | cmd.rd_kids;
    always_comb
    begin
        raddr_a = parent_idx;
        raddr_b = kid_r[ejh_pkg::ADDR_W-1:0];
        if (cmd.rd_root)
        begin
            raddr_a = '0;
            raddr_b = ejh_pkg::ADDR_W'(count_reg - ejh_pkg::CNT_W'(1));
        end
        else if (cmd.rd_kids)
        begin
            raddr_a = kid_l[ejh_pkg::ADDR_W-1:0];
        end
    end

    // write port data
    assign wr_en = cmd.wr_move_up | cmd.wr_move_down | cmd.wr_final;
    always_comb
    begin
        wr_data = job_reg;
        if (cmd.wr_move_up)
            wr_data = rd_a_reg;
        else if (cmd.wr_move_down)
            wr_data = child_job;
    end

    // heap storage, one write and two registered reads
    always_ff @(posedge clk)
    begin
        if (wr_en)
            heap_mem[idx_reg] <= wr_data;
        if (rd_en)
        begin
            rd_a_reg <= heap_mem[raddr_a];
            rd_b_reg <= heap_mem[raddr_b];
        end
    end

    assign in_job.tid = task_id;
    assign in_job.dl  = abs_deadline;
    assign in_job.ex  = last_exec_time;
    assign in_job.per = period;

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            cmd_reg <= command;
            job_reg <= in_job;
        end
        if (cmd.cap_pop)
        begin
            top_reg <= rd_a_reg;
            job_reg <= rd_b_reg;
        end
        if (cmd.res_set)
            res_reg <= cmd.res_code;
        if (cmd.push_begin)
            idx_reg <= ejh_pkg::ADDR_W'(count_reg);
        else if (cmd.cap_pop)
            idx_reg <= '0;
        else if (cmd.wr_move_up)
            idx_reg <= parent_idx;
        else if (cmd.wr_move_down)
            idx_reg <= child_idx;
    end

    // entry count and policy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            policy_reg <= ejh_pkg::POL_EDF;
        end
        else
        begin
            if (cfg_wr_en)
                policy_reg <= cfg_wr_data;
            if (cmd.push_begin)
                count_reg <= count_reg + ejh_pkg::CNT_W'(1);
            else if (cmd.cap_pop)
                count_reg <= count_reg - ejh_pkg::CNT_W'(1);
        end
    end

    // result register
    assign pop_ok = (cmd_reg == ejh_pkg::CMD_POP) && (res_reg == ejh_pkg::ST_OK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.ld_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_out)
        begin
            job_valid_reg  <= pop_ok;
            out_job_reg    <= pop_ok ? top_reg : '0;
            out_status_reg <= res_reg;
            out_count_reg  <= count_reg;
        end
    end

    assign out_valid          = out_valid_reg;
    assign job_valid          = job_valid_reg;
    assign out_task_id        = out_job_reg.tid;
    assign out_abs_deadline   = out_job_reg.dl;
    assign out_last_exec_time = out_job_reg.ex;
    assign out_period         = out_job_reg.per;
    assign status             = out_status_reg;
    assign is_empty           = (out_count_reg == '0);
    assign job_count          = out_count_reg;

endmodule

// ===== hdl/edf_rm_job_heap_top.sv =====
// Real-time job priority queue kept as a binary heap of up to 64 jobs.
// Input channel (in_valid/in_ready) carries one command word: a push of the
// job in task_id, abs_deadline, last_exec_time and period, or a pop.
// Output channel (out_valid/out_ready) returns one word per command: the
// popped job with job_valid, a status (ok, push into full heap, pop from
// empty heap), is_empty and the job count after the command.
// cfg_wr_en/cfg_wr_data set the ordering policy: 0 earliest deadline first,
// 1 rate monotonic. Write it only while no command is in flight.
// One command is worked at a time; each level is one registered read of the
// heap memory followed by one compare and write. A push ends when the job
// climbs to the root or when a parent stops it; a pop ends when the last
// entry reaches a leaf or when a child stops it. The result word turns
// valid in the same cycle that in_ready rises again. The worst case at 64
// entries is a push climbing six levels.
// The result sits in an output register, so the next command is accepted
// while a result waits; a stalled receiver holds the following result in
// the controller until the output register frees up.
// Reset empties the heap and selects earliest deadline first.
module edf_rm_job_heap_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic                       cfg_wr_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       command,
    input  logic [ejh_pkg::TID_W-1:0]  task_id,
    input  logic [ejh_pkg::TIME_W-1:0] abs_deadline,
    input  logic [ejh_pkg::TIME_W-1:0] last_exec_time,
    input  logic [ejh_pkg::TIME_W-1:0] period,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       job_valid,
    output logic [ejh_pkg::TID_W-1:0]  out_task_id,
    output logic [ejh_pkg::TIME_W-1:0] out_abs_deadline,
    output logic [ejh_pkg::TIME_W-1:0] out_last_exec_time,
    output logic [ejh_pkg::TIME_W-1:0] out_period,
    output logic [1:0]                 status,
    output logic                       is_empty,
    output logic [ejh_pkg::CNT_W-1:0]  job_count
);

    ejh_pkg::cmd_t  cmd;
    ejh_pkg::stat_t st;

    // controller
    ejh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    // datapath with heap memory
    ejh_dp u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .command            (command),
        .task_id            (task_id),
        .abs_deadline       (abs_deadline),
        .last_exec_time     (last_exec_time),
        .period             (period),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .job_valid          (job_valid),
        .out_task_id        (out_task_id),
        .out_abs_deadline   (out_abs_deadline),
        .out_last_exec_time (out_last_exec_time),
        .out_period         (out_period),
        .status             (status),
        .is_empty           (is_empty),
        .job_count          (job_count),
        .cmd                (cmd),
        .st                 (st)
    );

endmodule
